[sv/pewr_pkg.sv]
// Shared types, constants and tables for the pose error window RMSE block.
// Used by every module of the block but pewr_ram; depends on nothing else.
package pewr_pkg;

    localparam int WINDOW_MAX     = 128;
    localparam int SLOT_W         = $clog2(WINDOW_MAX);
    localparam int FILL_W         = SLOT_W + 1;
    localparam int WARMUP_SAMPLES = 10;
    localparam int WINDOW_RESET   = 100;

    localparam int PI_Q13         = 25736;
    localparam int TWO_PI_Q13     = 51472;
    localparam int HALF_PI_Q16    = 102944;
    localparam int POS_ERR_LIMIT  = 8388607;
    localparam int CORDIC_STEPS   = 17;
    localparam int NORM_LIMIT     = 1 << 30;
    localparam int RATIO_NUM      = 100000;
    localparam int RATIO_DEN      = 99999;

    localparam int IN_DATA_W      = 128;
    localparam int OUT_DATA_W     = 88;
    localparam int CFG_W          = 8;

    localparam int OPND_W         = 35;
    localparam int CORD_W         = 38;
    localparam int ANGLE_W        = 20;
    localparam int MUL_A_W        = 35;
    localparam int MUL_B_W        = 25;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;

    localparam int SUM_W          = 54;
    localparam int ROOT_W         = 27;
    localparam int DIV_STEPS      = SUM_W;
    localparam int SQRT_STEPS     = SUM_W / 2;
    localparam int RING_W         = 46 + 46 + 30 + 47;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QMUL,
        ST_QSUM,
        ST_CMP,
        ST_SEL,
        ST_CSTART,
        ST_CWAIT,
        ST_YAW,
        ST_ERR,
        ST_SQ,
        ST_RD,
        ST_PUSH,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_NORM,
        CS_ITER,
        CS_DONE
    } cordic_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } divsqrt_state_t;

    function automatic logic [ANGLE_W-1:0] atan_step(input logic [4:0] idx);
        logic [ANGLE_W-1:0] r;
        case (idx)
            5'd0:    r = 20'd51472;
            5'd1:    r = 20'd30385;
            5'd2:    r = 20'd16055;
            5'd3:    r = 20'd8150;
            5'd4:    r = 20'd4091;
            5'd5:    r = 20'd2047;
            5'd6:    r = 20'd1024;
            5'd7:    r = 20'd512;
            5'd8:    r = 20'd256;
            5'd9:    r = 20'd128;
            5'd10:   r = 20'd64;
            5'd11:   r = 20'd32;
            5'd12:   r = 20'd16;
            5'd13:   r = 20'd8;
            5'd14:   r = 20'd4;
            5'd15:   r = 20'd2;
            5'd16:   r = 20'd1;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

endpackage

[sv/pewr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing else.
module pewr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/pewr_cordic.sv]
// Iterative vectoring CORDIC that returns atan2(y, x) in units of 2^-16 rad.
// Depends on pewr_pkg for widths, state type and the arctangent table.
module pewr_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pewr_pkg::OPND_W-1:0]  y_in,
    input  logic signed [pewr_pkg::OPND_W-1:0]  x_in,
    output logic                                done,
    output logic signed [pewr_pkg::ANGLE_W-1:0] angle
);
    import pewr_pkg::*;

    cordic_state_t             state_reg, state_next;
    logic signed [CORD_W-1:0]  x_reg, y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    logic [4:0]                i_reg;
    logic signed [CORD_W-1:0]  xs, ys, dx, dy;
    logic                      under_limit;
    logic                      both_zero;

    assign xs          = CORD_W'(x_in);
    assign ys          = CORD_W'(y_in);
    assign both_zero   = (x_in == '0) && (y_in == '0);
    assign dx          = y_reg >>> i_reg;
    assign dy          = x_reg >>> i_reg;
    assign under_limit = (x_reg < CORD_W'(NORM_LIMIT)) && (x_reg > -CORD_W'(NORM_LIMIT))
                      && (y_reg < CORD_W'(NORM_LIMIT)) && (y_reg > -CORD_W'(NORM_LIMIT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    state_next = both_zero ? CS_DONE : CS_NORM;
                end
            end
            CS_NORM:
            begin
                if (!under_limit)
                begin
                    state_next = CS_ITER;
                end
            end
            CS_ITER:
            begin
                if (i_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == CS_DONE);
    end

    assign angle = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_IDLE:
            begin
                i_reg <= '0;
                if (both_zero || !x_in[OPND_W-1])
                begin
                    x_reg <= xs;
                    y_reg <= ys;
                    z_reg <= '0;
                end
                else if (!y_in[OPND_W-1])
                begin
                    x_reg <= ys;
                    y_reg <= -xs;
                    z_reg <= ANGLE_W'(HALF_PI_Q16);
                end
                else
                begin
                    x_reg <= -ys;
                    y_reg <= xs;
                    z_reg <= -ANGLE_W'(HALF_PI_Q16);
                end
            end
            CS_NORM:
            begin
                if (under_limit)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            CS_ITER:
            begin
                i_reg <= i_reg + 5'd1;
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + $signed(atan_step(i_reg));
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - $signed(atan_step(i_reg));
                end
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

endmodule

[sv/pewr_divsqrt.sv]
// Iterative unit: restoring division of a sum by the fill count, then a
// bit-pair integer square root of the quotient. Depends on pewr_pkg.
module pewr_divsqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pewr_pkg::SUM_W-1:0]  num,
    input  logic [pewr_pkg::FILL_W-1:0] den,
    output logic                        done,
    output logic [pewr_pkg::ROOT_W-1:0] root
);
    import pewr_pkg::*;

    divsqrt_state_t    state_reg, state_next;
    logic [SUM_W-1:0]  val_reg;
    logic [FILL_W-1:0] rem_reg, den_reg;
    logic [SUM_W:0]    root_reg;
    logic [SUM_W-1:0]  bit_reg;
    logic [5:0]        cnt_reg;
    logic [FILL_W:0]   rs;
    logic              ge;
    logic [SUM_W:0]    trial;
    logic              fits;

    assign rs    = {rem_reg, val_reg[SUM_W-1]};
    assign ge    = rs >= {1'b0, den_reg};
    assign trial = root_reg + {1'b0, bit_reg};
    assign fits  = {1'b0, val_reg} >= trial;
    assign root  = root_reg[ROOT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    state_next = DS_DIV;
                end
            end
            DS_DIV:
            begin
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = DS_SQRT;
                end
            end
            DS_SQRT:
            begin
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                begin
                    state_next = DS_DONE;
                end
            end
            DS_DONE:
            begin
                state_next = DS_IDLE;
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == DS_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DS_IDLE:
            begin
                val_reg <= num;
                rem_reg <= '0;
                den_reg <= (den == '0) ? FILL_W'(1) : den;
                cnt_reg <= '0;
            end
            DS_DIV:
            begin
                rem_reg <= ge ? FILL_W'(rs - {1'b0, den_reg}) : rs[FILL_W-1:0];
                val_reg <= {val_reg[SUM_W-2:0], ge};
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    cnt_reg  <= '0;
                    root_reg <= '0;
                    bit_reg  <= SUM_W'(1) << (SUM_W - 2);
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            DS_SQRT:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                bit_reg <= bit_reg >> 2;
                if (fits)
                begin
                    val_reg  <= val_reg - trial[SUM_W-1:0];
                    root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

[sv/pose_error_window_rmse.sv]
// Top level: sequencer with one shared multiplier, the error ring RAM,
// the CORDIC and the divide/root unit. Depends on pewr_pkg and all submodules.
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: pos_x, pos_y, quat_x, quat_y, quat_z, quat_w; tuser: action
// m_axis    out  tdata: rmse_pos_x, rmse_pos_y, rmse_heading, rmse_planar
// cfg       in   cfg_wr_data: window_length
//
// A ground-truth beat's processing time is set mostly by the CORDIC pre-scaling and
// its 17 steps. An estimate then computes the errors and updates the ring; an
// emitting one adds four passes through the divide/root unit and the output load.
// The input is ready only in idle. A result waiting in the output register does
// not stop the next beat; only the final load waits for it. Reset is asynchronous.
module pose_error_window_rmse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
    input  logic [pewr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rmse_pos_x, rmse_pos_y, rmse_heading, rmse_planar, zero pad
    output logic [pewr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [pewr_pkg::CFG_W-1:0]        cfg_wr_data
);
    import pewr_pkg::*;

    top_state_t               state_reg, state_next;
    logic [2:0]               idx_reg;
    logic [1:0]               chan_reg;
    logic [CFG_W-1:0]         window_reg;

    logic                     act_reg;
    logic signed [31:0]       px_reg, py_reg;
    logic signed [15:0]       qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [31:0]       prod_reg [8];
    logic signed [OPND_W-1:0] n_reg, s_reg, cy_reg, cx_reg;
    logic signed [50:0]       ln_reg, ls_reg;
    logic                     neg_reg, pos_reg;
    logic signed [OPND_W-1:0] opy_reg, opx_reg;

    logic signed [31:0]       truth_x_reg, truth_y_reg;
    logic signed [15:0]       truth_h_reg;
    logic                     truth_seen_reg;
    logic [3:0]               warmup_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     drop_reg;
    logic [52:0]              sum_x_reg, sum_y_reg;
    logic [36:0]              sum_h_reg;
    logic [53:0]              sum_p_reg;

    logic signed [15:0]       yaw_reg;
    logic signed [23:0]       ex_reg, ey_reg;
    logic signed [16:0]       eh_reg;
    logic [45:0]              sq_x_reg, sq_y_reg;
    logic [29:0]              sq_h_reg;
    logic [ROOT_W-1:0]        res_reg [4];

    logic                     m_valid_reg;
    logic [OUT_DATA_W-1:0]    m_data_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                     c_start, c_done;
    logic signed [ANGLE_W-1:0] c_angle;
    logic                     d_start, d_done;
    logic [SUM_W-1:0]         d_num;
    logic [ROOT_W-1:0]        d_root;
    logic                     rd_en, wr_en, out_load;
    logic [SLOT_W-1:0]        rd_addr;
    logic [RING_W-1:0]        rd_data;
    logic [45:0]              old_x, old_y;
    logic [29:0]              old_h;
    logic [46:0]              old_p, sq_p;

    logic [FILL_W-1:0]        len;
    logic signed [20:0]       a_w, v_w, yaw_w;
    logic signed [32:0]       dxe, dye;
    logic signed [16:0]       dh;
    logic signed [23:0]       ex_w, ey_w;
    logic signed [16:0]       eh_w;
    logic [3:0]               warm_inc;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_QMUL:
            begin
                case (idx_reg)
                    3'd0:    begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qx_reg); end
                    3'd1:    begin mul_a = MUL_A_W'(qy_reg); mul_b = MUL_B_W'(qy_reg); end
                    3'd2:    begin mul_a = MUL_A_W'(qz_reg); mul_b = MUL_B_W'(qz_reg); end
                    3'd3:    begin mul_a = MUL_A_W'(qw_reg); mul_b = MUL_B_W'(qw_reg); end
                    3'd4:    begin mul_a = MUL_A_W'(qw_reg); mul_b = MUL_B_W'(qy_reg); end
                    3'd5:    begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qz_reg); end
                    3'd6:    begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qy_reg); end
                    default: begin mul_a = MUL_A_W'(qw_reg); mul_b = MUL_B_W'(qz_reg); end
                endcase
            end
            ST_CMP:
            begin
                if (idx_reg == 3'd0)
                begin
                    mul_a = n_reg;
                    mul_b = MUL_B_W'(RATIO_DEN);
                end
                else
                begin
                    mul_a = s_reg;
                    mul_b = MUL_B_W'(RATIO_NUM);
                end
            end
            ST_SQ:
            begin
                case (idx_reg)
                    3'd0:    begin mul_a = MUL_A_W'(ex_reg); mul_b = MUL_B_W'(ex_reg); end
                    3'd1:    begin mul_a = MUL_A_W'(ey_reg); mul_b = MUL_B_W'(ey_reg); end
                    default: begin mul_a = MUL_A_W'(eh_reg); mul_b = MUL_B_W'(eh_reg); end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Yaw from the CORDIC angle: scale by the mode, round to Q3.13, wrap once.
    always_comb
    begin
        if (neg_reg)
        begin
            a_w = -(21'(c_angle) <<< 1);
        end
        else if (pos_reg)
        begin
            a_w = 21'(c_angle) <<< 1;
        end
        else
        begin
            a_w = 21'(c_angle);
        end
        v_w = (a_w + 21'sd4) >>> 3;
        if (v_w >= 21'(PI_Q13))
        begin
            yaw_w = v_w - 21'(TWO_PI_Q13);
        end
        else if (v_w < -21'(PI_Q13))
        begin
            yaw_w = v_w + 21'(TWO_PI_Q13);
        end
        else
        begin
            yaw_w = v_w;
        end
    end

    always_comb
    begin
        dxe = 33'(truth_x_reg) - 33'(px_reg);
        dye = 33'(truth_y_reg) - 33'(py_reg);
        if (dxe > 33'(POS_ERR_LIMIT))
        begin
            ex_w = 24'(POS_ERR_LIMIT);
        end
        else if (dxe < -33'(POS_ERR_LIMIT))
        begin
            ex_w = -24'(POS_ERR_LIMIT);
        end
        else
        begin
            ex_w = dxe[23:0];
        end
        if (dye > 33'(POS_ERR_LIMIT))
        begin
            ey_w = 24'(POS_ERR_LIMIT);
        end
        else if (dye < -33'(POS_ERR_LIMIT))
        begin
            ey_w = -24'(POS_ERR_LIMIT);
        end
        else
        begin
            ey_w = dye[23:0];
        end
        dh = 17'(truth_h_reg) - 17'(yaw_reg);
        if (dh >= 17'(PI_Q13))
        begin
            eh_w = dh - 17'(TWO_PI_Q13);
        end
        else if (dh < -17'(PI_Q13))
        begin
            eh_w = dh + 17'(TWO_PI_Q13);
        end
        else
        begin
            eh_w = dh;
        end
    end

    always_comb
    begin
        if (window_reg == '0)
        begin
            len = FILL_W'(1);
        end
        else if (FILL_W'(window_reg) > FILL_W'(WINDOW_MAX))
        begin
            len = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            len = FILL_W'(window_reg);
        end
    end

    assign rd_addr  = slot_reg - fill_reg[SLOT_W-1:0];
    assign old_x    = drop_reg ? rd_data[45:0] : '0;
    assign old_y    = drop_reg ? rd_data[91:46] : '0;
    assign old_h    = drop_reg ? rd_data[121:92] : '0;
    assign old_p    = drop_reg ? rd_data[168:122] : '0;
    assign sq_p     = 47'(sq_x_reg) + 47'(sq_y_reg);
    assign warm_inc = (warmup_reg < 4'(WARMUP_SAMPLES)) ? warmup_reg + 4'd1 : warmup_reg;

    always_comb
    begin
        case (chan_reg)
            2'd0:    d_num = SUM_W'(sum_x_reg);
            2'd1:    d_num = SUM_W'(sum_y_reg);
            2'd2:    d_num = SUM_W'(sum_h_reg);
            default: d_num = sum_p_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL:
            begin
                if (idx_reg == 3'd7)
                begin
                    state_next = ST_QSUM;
                end
            end
            ST_QSUM:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (idx_reg == 3'd1)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = ST_CSTART;
            end
            ST_CSTART:
            begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (c_done)
                begin
                    state_next = ST_YAW;
                end
            end
            ST_YAW:
            begin
                if (!act_reg || !truth_seen_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (idx_reg == 3'd2)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (warm_inc < 4'(WARMUP_SAMPLES))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (d_done)
                begin
                    state_next = (chan_reg == 2'd3) ? ST_OUT : ST_DSTART;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        c_start       = (state_reg == ST_CSTART);
        d_start       = (state_reg == ST_DSTART);
        rd_en         = (state_reg == ST_RD);
        wr_en         = (state_reg == ST_PUSH);
        out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            chan_reg       <= '0;
            window_reg     <= CFG_W'(WINDOW_RESET);
            truth_x_reg    <= '0;
            truth_y_reg    <= '0;
            truth_h_reg    <= '0;
            truth_seen_reg <= 1'b0;
            warmup_reg     <= '0;
            fill_reg       <= '0;
            slot_reg       <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_h_reg      <= '0;
            sum_p_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            case (state_reg)
                ST_QMUL:
                begin
                    idx_reg <= (idx_reg == 3'd7) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_CMP:
                begin
                    idx_reg <= (idx_reg == 3'd1) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_SQ:
                begin
                    idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_YAW:
                begin
                    if (!act_reg)
                    begin
                        truth_x_reg    <= px_reg;
                        truth_y_reg    <= py_reg;
                        truth_h_reg    <= yaw_w[15:0];
                        truth_seen_reg <= 1'b1;
                    end
                end
                ST_PUSH:
                begin
                    sum_x_reg  <= sum_x_reg - 53'(old_x) + 53'(sq_x_reg);
                    sum_y_reg  <= sum_y_reg - 53'(old_y) + 53'(sq_y_reg);
                    sum_h_reg  <= sum_h_reg - 37'(old_h) + 37'(sq_h_reg);
                    sum_p_reg  <= sum_p_reg - 54'(old_p) + 54'(sq_p);
                    fill_reg   <= drop_reg ? fill_reg : fill_reg + FILL_W'(1);
                    slot_reg   <= slot_reg + SLOT_W'(1);
                    warmup_reg <= warm_inc;
                    chan_reg   <= '0;
                end
                ST_DWAIT:
                begin
                    if (d_done)
                    begin
                        chan_reg <= chan_reg + 2'd1;
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                act_reg <= s_axis_tuser;
                px_reg  <= s_axis_tdata[31:0];
                py_reg  <= s_axis_tdata[63:32];
                qx_reg  <= s_axis_tdata[79:64];
                qy_reg  <= s_axis_tdata[95:80];
                qz_reg  <= s_axis_tdata[111:96];
                qw_reg  <= s_axis_tdata[127:112];
            end
            ST_QMUL:
            begin
                prod_reg[idx_reg] <= mul_p[31:0];
            end
            ST_QSUM:
            begin
                n_reg  <= OPND_W'(prod_reg[0]) + OPND_W'(prod_reg[1])
                        + OPND_W'(prod_reg[2]) + OPND_W'(prod_reg[3]);
                s_reg  <= (OPND_W'(prod_reg[4]) - OPND_W'(prod_reg[5])) <<< 1;
                cy_reg <= (OPND_W'(prod_reg[6]) + OPND_W'(prod_reg[7])) <<< 1;
                cx_reg <= OPND_W'(prod_reg[3]) + OPND_W'(prod_reg[0])
                        - OPND_W'(prod_reg[1]) - OPND_W'(prod_reg[2]);
            end
            ST_CMP:
            begin
                if (idx_reg == 3'd0)
                begin
                    ln_reg <= mul_p[50:0];
                end
                else
                begin
                    ls_reg <= mul_p[50:0];
                end
            end
            ST_SEL:
            begin
                neg_reg <= (n_reg > 0) && (ls_reg <= -ln_reg);
                pos_reg <= (n_reg > 0) && !(ls_reg <= -ln_reg) && (ls_reg >= ln_reg);
                if ((n_reg > 0) && ((ls_reg <= -ln_reg) || (ls_reg >= ln_reg)))
                begin
                    opy_reg <= OPND_W'(qy_reg);
                    opx_reg <= OPND_W'(qx_reg);
                end
                else
                begin
                    opy_reg <= cy_reg;
                    opx_reg <= cx_reg;
                end
            end
            ST_YAW:
            begin
                yaw_reg <= yaw_w[15:0];
            end
            ST_ERR:
            begin
                ex_reg <= ex_w;
                ey_reg <= ey_w;
                eh_reg <= eh_w;
            end
            ST_SQ:
            begin
                case (idx_reg)
                    3'd0:    sq_x_reg <= mul_p[45:0];
                    3'd1:    sq_y_reg <= mul_p[45:0];
                    default: sq_h_reg <= mul_p[29:0];
                endcase
            end
            ST_RD:
            begin
                drop_reg <= (fill_reg >= len);
            end
            ST_DWAIT:
            begin
                if (d_done)
                begin
                    res_reg[chan_reg] <= d_root;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_data_reg <= {3'b000, res_reg[3][23:0], res_reg[2][14:0],
                                   res_reg[1][22:0], res_reg[0][22:0]};
                end
            end
            default:
            begin
                yaw_reg <= yaw_reg;
            end
        endcase
    end

    pewr_ram #(
        .WIDTH (RING_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data ({sq_p, sq_h_reg, sq_y_reg, sq_x_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pewr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .y_in  (opy_reg),
        .x_in  (opx_reg),
        .done  (c_done),
        .angle (c_angle)
    );

    pewr_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (d_start),
        .num   (d_num),
        .den   (fill_reg),
        .done  (d_done),
        .root  (d_root)
    );

endmodule

[verif/pewr_checker.sv]
// Checker for the pose error window RMSE block: watches the input, output and
// register channels, predicts each result and compares it. Depends on pewr_pkg.
module pewr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [pewr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [pewr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [pewr_pkg::CFG_W-1:0]          cfg_wr_data,
    output int                                  errors,
    output int                                  pending
);
    import pewr_pkg::*;

    typedef struct packed {
        logic [23:0] planar;
        logic [14:0] heading;
        logic [22:0] py;
        logic [22:0] px;
    } rmse_t;

    rmse_t       rmse_q[$];
    logic [7:0]  win_len;
    longint      gt_x, gt_y, gt_yaw;
    bit          gt_seen;
    int          warm, fill, slot;
    longint      rx[WINDOW_MAX], ry[WINDOW_MAX], rh[WINDOW_MAX], rp[WINDOW_MAX];
    longint      sx, sy, sh, sp;

    assign pending = rmse_q.size();

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin t = y; y = -x; x = t; z = HALF_PI_Q16; end
            else begin t = -y; y = x; x = t; z = -HALF_PI_Q16; end
        end
        while (absval(x) < NORM_LIMIT && absval(y) < NORM_LIMIT) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0) begin x += dx; y -= dy; z += longint'(atan_step(5'(i))); end
            else begin x -= dx; y += dy; z -= longint'(atan_step(5'(i))); end
        end
        return z;
    endfunction

    function automatic longint wrap_pi(longint v);
        longint m;
        m = (v + PI_Q13) % TWO_PI_Q13;
        if (m < 0) m += TWO_PI_Q13;
        return m - PI_Q13;
    endfunction

    function automatic longint quat_yaw(longint qx, longint qy, longint qz, longint qw);
        longint n, s, a;
        n = qx*qx + qy*qy + qz*qz + qw*qw;
        s = 2 * (qw*qy - qx*qz);
        if (n > 0 && s * RATIO_NUM <= -(n * RATIO_DEN)) a = -2 * cordic_angle(qy, qx);
        else if (n > 0 && s * RATIO_NUM >= n * RATIO_DEN) a = 2 * cordic_angle(qy, qx);
        else a = cordic_angle(2 * (qx*qy + qw*qz), qw*qw + qx*qx - qy*qy - qz*qz);
        return wrap_pi(shr(a + 4, 3));
    endfunction

    function automatic longint clip_pos(longint v);
        if (v > POS_ERR_LIMIT) return POS_ERR_LIMIT;
        if (v < -POS_ERR_LIMIT) return -POS_ERR_LIMIT;
        return v;
    endfunction

    function automatic longint int_root(longint v);
        longint r, b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_rmse(input logic [IN_DATA_W-1:0] d, input logic act);
        longint px, py, yaw, ex, ey, eh, qx, qy, qz, qw, ax, ay, ah;
        int len, old, n;
        rmse_t r;
        px = longint'(signed'(d[31:0]));
        py = longint'(signed'(d[63:32]));
        qx = longint'(signed'(d[79:64]));
        qy = longint'(signed'(d[95:80]));
        qz = longint'(signed'(d[111:96]));
        qw = longint'(signed'(d[127:112]));
        yaw = quat_yaw(qx, qy, qz, qw);
        if (!act) begin
            gt_x = px; gt_y = py; gt_yaw = yaw; gt_seen = 1;
            return;
        end
        if (!gt_seen) return;
        ex = clip_pos(gt_x - px);
        ey = clip_pos(gt_y - py);
        eh = wrap_pi(gt_yaw - yaw);
        ax = ex*ex; ay = ey*ey; ah = eh*eh;
        len = win_len;
        if (len < 1) len = 1;
        if (len > WINDOW_MAX) len = WINDOW_MAX;
        if (fill >= len && fill > 0) begin
            old = (slot + WINDOW_MAX - fill) % WINDOW_MAX;
            sx -= rx[old]; sy -= ry[old]; sh -= rh[old]; sp -= rp[old];
            fill--;
        end
        rx[slot] = ax; ry[slot] = ay; rh[slot] = ah; rp[slot] = ax + ay;
        sx += ax; sy += ay; sh += ah; sp += ax + ay;
        fill++;
        slot = (slot + 1) % WINDOW_MAX;
        if (warm < WARMUP_SAMPLES) warm++;
        if (warm < WARMUP_SAMPLES) return;
        n = (fill != 0) ? fill : 1;
        r.px = 23'(int_root(sx / n));
        r.py = 23'(int_root(sy / n));
        r.heading = 15'(int_root(sh / n));
        r.planar = 24'(int_root(sp / n));
        rmse_q.insert(rmse_q.size(), r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        rmse_t got, want;
        if (!rst_n) begin
            win_len = 8'(WINDOW_RESET);
            gt_x = 0; gt_y = 0; gt_yaw = 0; gt_seen = 0;
            warm = 0; fill = 0; slot = 0;
            sx = 0; sy = 0; sh = 0; sp = 0;
            errors = 0;
            rmse_q.delete();
        end else begin
            if (cfg_wr_en) win_len = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(rmse_t)-1:0];
                if (rmse_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    errors++;
                end else begin
                    want = rmse_q[0];
                    rmse_q.delete(0);
                    if (got.px !== want.px) begin
                        $display("%0t: rmse_pos_x exp %0d got %0d", $realtime, want.px, got.px);
                        errors++;
                    end
                    if (got.py !== want.py) begin
                        $display("%0t: rmse_pos_y exp %0d got %0d", $realtime, want.py, got.py);
                        errors++;
                    end
                    if (got.heading !== want.heading) begin
                        $display("%0t: rmse_heading exp %0d got %0d", $realtime,
                                 want.heading, got.heading);
                        errors++;
                    end
                    if (got.planar !== want.planar) begin
                        $display("%0t: rmse_planar exp %0d got %0d", $realtime,
                                 want.planar, got.planar);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_rmse(s_axis_tdata, s_axis_tuser);
        end
    end
endmodule

[verif/pose_error_window_rmse_tb.sv]
// Testbench top for the pose error window RMSE block: drives pose beats and
// window settings, stalls the output, and reports the verdict from pewr_checker.
module pose_error_window_rmse_tb;
    import pewr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;
    int                    errors;
    int                    pending;
    int                    send_idle;
    int                    recv_stall;
    int                    hold_off;
    bit                    hold_req;
    bit                    hold_armed;

    localparam logic ACT_TRUTH = 1'b0;
    localparam logic ACT_EST   = 1'b1;

    pose_error_window_rmse uut (.*);

    pewr_checker chk (.*);

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #60000000;
        $display("pose_error_window_rmse_tb: errors");
        $finish;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 0;
            hold_off <= 0;
            hold_armed <= 0;
        end else if (hold_req && !hold_armed) begin
            m_axis_tready <= 0;
            hold_off <= 3000;
            hold_armed <= 1;
        end else if (hold_off > 0) begin
            m_axis_tready <= 0;
            hold_off <= hold_off - 1;
        end else m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($urandom_range(2000000)) - 32'd1000000;
        endcase
    endfunction

    task automatic send_pose(input logic act, input logic [31:0] x, input logic [31:0] y,
                             input logic [15:0] qx, input logic [15:0] qy,
                             input logic [15:0] qz, input logic [15:0] qw);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {qw, qz, qy, qx, y, x};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_random();
        send_pose(($urandom_range(3) == 0) ? ACT_TRUTH : ACT_EST, rand_pos(), rand_pos(),
                  rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endtask

    task automatic drain_and_set(input logic [7:0] len);
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0 && guard < 2000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (500) @(posedge clk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 0;
    endtask

    initial begin
        int guard;
        logic [7:0] lens[6];
        lens = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd5, 8'd37};
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_req = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        drain_and_set(8'd3);
        // Estimates before any ground truth must be dropped.
        send_pose(ACT_EST, 32'd5, 32'd5, 16'd0, 16'd0, 16'd0, 16'd16384);
        send_pose(ACT_TRUTH, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pose(ACT_EST, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd16384, 16'd0);
        send_pose(ACT_EST, 32'd0, 32'd0, 16'd0, 16'd16384, 16'd0, 16'd16384);
        send_pose(ACT_EST, 32'd0, 32'd0, 16'd0, -16'sd16384, 16'd0, 16'd16384);
        send_pose(ACT_EST, 32'd0, 32'd0, -16'sd16384, 16'd0, 16'd0, 16'd1);
        send_pose(ACT_TRUTH, 32'd0, 32'd0, 16'd0, 16'd0, 16'd16384, 16'd1);
        for (int i = 0; i < 14; i++)
            send_pose(ACT_EST, 32'hFFFF_FFFF, 32'd65536, rand_quat(), rand_quat(),
                      rand_quat(), rand_quat());
        drain_and_set(8'd100);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 70; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 70; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            if (ph == 2) hold_req = 1;
            for (int i = 0; i < 120; i++) send_random();
            if (ph < 6) drain_and_set(lens[ph]);
            else begin
                send_idle = 0;
                recv_stall = 0;
                for (int i = 0; i < 12; i++)
                    send_pose(ACT_EST, rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                              rand_quat(), rand_quat());
            end
        end
        s_axis_tvalid <= 0;
        send_idle = 0;
        recv_stall = 0;
        guard = 0;
        @(posedge clk);
        while (pending != 0 && guard < 2000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (600) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("pose_error_window_rmse_tb: clean");
        else
            $display("pose_error_window_rmse_tb: errors");
        $finish;
    end
endmodule
